// File: hw/rtl/kic_pkg.sv
// shared types and constants for the keypad integer calculator
`timescale 1ns / 1ps
`default_nettype none

package kic_pkg;

    // widths of the key and result fields
    localparam int CMD_W       = 3;
    localparam int DIGIT_W     = 4;
    localparam int VALUE_W     = 35;
    localparam int OPER_W      = 3;
    localparam int WORD_W      = 32;

    // longest decimal entry
    localparam int MAX_DIGITS  = 10;
    localparam int DIGITS_W    = $clog2(MAX_DIGITS + 1);

    // divider iterations, one quotient bit each
    localparam int DIV_STEPS   = WORD_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);

    typedef enum logic [CMD_W-1:0] {
        CMD_DIGIT = 3'd0,
        CMD_CLEAR = 3'd1,
        CMD_EVAL  = 3'd2,
        CMD_ADD   = 3'd3,
        CMD_SUB   = 3'd4,
        CMD_MUL   = 3'd5,
        CMD_DIV   = 3'd6,
        CMD_MOD   = 3'd7
    } key_cmd_t;

    typedef enum logic [OPER_W-1:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_MOD  = 3'd5
    } oper_t;

    // operator keys map onto operator codes by this offset
    localparam logic [CMD_W-1:0] OPER_KEY_OFFSET = CMD_W'(2);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic apply;
    } kic_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic needs_div;
    } kic_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/kic_datapath.sv
// calculator state, serial divider and key evaluation
`timescale 1ns / 1ps
`default_nettype none

module kic_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire kic_pkg::kic_ctrl_t                ctrl,
    output kic_pkg::kic_stat_t                     stat,
    input  wire logic [kic_pkg::CMD_W-1:0]         command,
    input  wire logic [kic_pkg::DIGIT_W-1:0]       digit,
    output logic signed [kic_pkg::VALUE_W-1:0]     shown_value,
    output logic                                   shown_error,
    output logic [kic_pkg::OPER_W-1:0]             waiting_operator
);

    // calculator state
    logic [kic_pkg::VALUE_W-1:0]  entry_value_reg, entry_value_next;
    logic [kic_pkg::DIGITS_W-1:0] entry_digits_reg, entry_digits_next;
    logic [kic_pkg::WORD_W-1:0]   running_total_reg, running_total_next;
    kic_pkg::oper_t               held_operator_reg, held_operator_next;
    logic                         start_new_entry_reg, start_new_entry_next;
    logic                         error_latched_reg, error_latched_next;

    // latched key
    kic_pkg::key_cmd_t            key_cmd_reg;
    logic [kic_pkg::DIGIT_W-1:0]  key_digit_reg;

    // divider on magnitudes
    logic [kic_pkg::WORD_W-1:0]   rem_reg, quo_reg, divisor_reg;
    logic                         q_neg_reg, r_neg_reg;
    logic [kic_pkg::WORD_W:0]     div_shift, div_diff;
    logic                         div_borrow;

    // result register
    logic signed [kic_pkg::VALUE_W-1:0] shown_value_reg;
    logic                               shown_error_reg;
    logic [kic_pkg::OPER_W-1:0]         waiting_operator_reg;

    logic [kic_pkg::WORD_W-1:0]   operand, total_mag, operand_mag;
    logic [kic_pkg::WORD_W-1:0]   product, quo_signed, rem_signed, comb_res;
    logic                         div_zero, evaluating, in_is_oper;
    kic_pkg::key_cmd_t            cmd_in;

    assign operand     = entry_value_reg[kic_pkg::WORD_W-1:0];
    assign total_mag   = running_total_reg[kic_pkg::WORD_W-1]
                         ? (~running_total_reg + kic_pkg::WORD_W'(1)) : running_total_reg;
    assign operand_mag = operand[kic_pkg::WORD_W-1]
                         ? (~operand + kic_pkg::WORD_W'(1)) : operand;

    // decide at transfer time whether the key runs the divider
    always_comb
    begin
        cmd_in     = kic_pkg::key_cmd_t'(command);
        in_is_oper = cmd_in inside {kic_pkg::CMD_ADD, kic_pkg::CMD_SUB, kic_pkg::CMD_MUL,
                                    kic_pkg::CMD_DIV, kic_pkg::CMD_MOD};
        stat.needs_div = !error_latched_reg
                         && (held_operator_reg inside {kic_pkg::OP_DIV, kic_pkg::OP_MOD})
                         && (cmd_in == kic_pkg::CMD_EVAL || (in_is_oper && !start_new_entry_reg))
                         && (operand != '0);
    end

    assign div_shift  = {rem_reg, quo_reg[kic_pkg::WORD_W-1]};
    assign div_borrow = div_shift < {1'b0, divisor_reg};
    assign div_diff   = div_shift - {1'b0, divisor_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            key_cmd_reg   <= cmd_in;
            key_digit_reg <= digit;
            rem_reg       <= '0;
            quo_reg       <= total_mag;
            divisor_reg   <= operand_mag;
            q_neg_reg     <= running_total_reg[kic_pkg::WORD_W-1] ^ operand[kic_pkg::WORD_W-1];
            r_neg_reg     <= running_total_reg[kic_pkg::WORD_W-1];
        end
        else if (ctrl.div_step)
        begin
            rem_reg <= div_borrow ? div_shift[kic_pkg::WORD_W-1:0]
                                  : div_diff[kic_pkg::WORD_W-1:0];
            quo_reg <= {quo_reg[kic_pkg::WORD_W-2:0], !div_borrow};
        end
    end

    assign product    = running_total_reg * operand;
    assign quo_signed = q_neg_reg ? (~quo_reg + kic_pkg::WORD_W'(1)) : quo_reg;
    assign rem_signed = r_neg_reg ? (~rem_reg + kic_pkg::WORD_W'(1)) : rem_reg;

    always_comb
    begin
        case (held_operator_reg)
            kic_pkg::OP_ADD: comb_res = running_total_reg + operand;
            kic_pkg::OP_SUB: comb_res = running_total_reg - operand;
            kic_pkg::OP_MUL: comb_res = product;
            kic_pkg::OP_DIV: comb_res = quo_signed;
            kic_pkg::OP_MOD: comb_res = rem_signed;
            default:         comb_res = operand;
        endcase
        div_zero = (held_operator_reg inside {kic_pkg::OP_DIV, kic_pkg::OP_MOD})
                   && (operand == '0);
    end

    // next state for the latched key
    always_comb
    begin
        entry_value_next     = entry_value_reg;
        entry_digits_next    = entry_digits_reg;
        running_total_next   = running_total_reg;
        held_operator_next   = held_operator_reg;
        start_new_entry_next = start_new_entry_reg;
        error_latched_next   = error_latched_reg;
        evaluating           = 1'b0;

        if (key_cmd_reg == kic_pkg::CMD_CLEAR)
        begin
            entry_value_next     = '0;
            entry_digits_next    = kic_pkg::DIGITS_W'(1);
            running_total_next   = '0;
            held_operator_next   = kic_pkg::OP_NONE;
            start_new_entry_next = 1'b1;
            error_latched_next   = 1'b0;
        end
        else if (!error_latched_reg)
        begin
            case (key_cmd_reg)
                kic_pkg::CMD_DIGIT:
                begin
                    if (key_digit_reg <= kic_pkg::DIGIT_MAX)
                    begin
                        if (start_new_entry_reg)
                        begin
                            entry_value_next     = kic_pkg::VALUE_W'(key_digit_reg);
                            entry_digits_next    = kic_pkg::DIGITS_W'(1);
                            start_new_entry_next = 1'b0;
                        end
                        else if (entry_digits_reg < kic_pkg::DIGITS_W'(kic_pkg::MAX_DIGITS))
                        begin
                            // a lone zero is replaced, not extended
                            if (entry_digits_reg == kic_pkg::DIGITS_W'(1)
                                && entry_value_reg == '0)
                            begin
                                entry_value_next = kic_pkg::VALUE_W'(key_digit_reg);
                            end
                            else
                            begin
                                entry_value_next =
                                    {entry_value_reg[kic_pkg::VALUE_W-4:0], 3'b000}
                                    + {entry_value_reg[kic_pkg::VALUE_W-2:0], 1'b0}
                                    + kic_pkg::VALUE_W'(key_digit_reg);
                                entry_digits_next = entry_digits_reg + kic_pkg::DIGITS_W'(1);
                            end
                        end
                    end
                end
                kic_pkg::CMD_CLEAR:
                begin
                end
                kic_pkg::CMD_EVAL:
                begin
                    if (held_operator_reg != kic_pkg::OP_NONE)
                    begin
                        evaluating           = 1'b1;
                        held_operator_next   = kic_pkg::OP_NONE;
                        start_new_entry_next = 1'b1;
                    end
                end
                default:
                begin
                    held_operator_next   = kic_pkg::oper_t'(key_cmd_reg - kic_pkg::OPER_KEY_OFFSET);
                    start_new_entry_next = 1'b1;
                    if (held_operator_reg != kic_pkg::OP_NONE && !start_new_entry_reg)
                        evaluating = 1'b1;
                    else
                        running_total_next = operand;
                end
            endcase

            if (evaluating)
            begin
                if (div_zero)
                begin
                    // error leaves the start flag as it was
                    error_latched_next   = 1'b1;
                    entry_value_next     = '0;
                    held_operator_next   = kic_pkg::OP_NONE;
                    start_new_entry_next = start_new_entry_reg;
                end
                else
                begin
                    running_total_next = comb_res;
                    entry_value_next   = {{(kic_pkg::VALUE_W-kic_pkg::WORD_W)
                                           {comb_res[kic_pkg::WORD_W-1]}}, comb_res};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_value_reg     <= '0;
            entry_digits_reg    <= kic_pkg::DIGITS_W'(1);
            running_total_reg   <= '0;
            held_operator_reg   <= kic_pkg::OP_NONE;
            start_new_entry_reg <= 1'b1;
            error_latched_reg   <= 1'b0;
        end
        else if (ctrl.apply)
        begin
            entry_value_reg     <= entry_value_next;
            entry_digits_reg    <= entry_digits_next;
            running_total_reg   <= running_total_next;
            held_operator_reg   <= held_operator_next;
            start_new_entry_reg <= start_new_entry_next;
            error_latched_reg   <= error_latched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.apply)
        begin
            shown_value_reg      <= error_latched_next ? '0 : signed'(entry_value_next);
            shown_error_reg      <= error_latched_next;
            waiting_operator_reg <= held_operator_next;
        end
    end

    assign shown_value      = shown_value_reg;
    assign shown_error      = shown_error_reg;
    assign waiting_operator = waiting_operator_reg;

endmodule

`default_nettype wire

// File: hw/rtl/kic_controller.sv
// sequencing of key transfer, divide iterations and result update
`timescale 1ns / 1ps
`default_nettype none

module kic_controller (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                key_valid,
    output logic                     key_stall,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output kic_pkg::kic_ctrl_t       ctrl,
    input  wire kic_pkg::kic_stat_t  stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_APPLY
    } state_t;

    state_t                        state_reg, state_next;
    logic [kic_pkg::DIV_CNT_W-1:0] step_cnt_reg, step_cnt_next;
    logic                          result_valid_reg, result_valid_next;
    logic                          ready, accept;

    // a new key only once the result slot is free or draining
    assign ready  = (state_reg == ST_IDLE) && (!result_valid_reg || !result_stall);
    assign accept = ready && key_valid;

    always_comb
    begin
        state_next        = state_reg;
        step_cnt_next     = step_cnt_reg;
        result_valid_next = result_valid_reg && result_stall;
        ctrl.load         = 1'b0;
        ctrl.div_step     = 1'b0;
        ctrl.apply        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load     = 1'b1;
                    step_cnt_next = '0;
                    state_next    = stat.needs_div ? ST_DIV : ST_APPLY;
                end
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                step_cnt_next = step_cnt_reg + kic_pkg::DIV_CNT_W'(1);
                if (step_cnt_reg == kic_pkg::DIV_CNT_W'(kic_pkg::DIV_STEPS - 1))
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                ctrl.apply        = 1'b1;
                result_valid_next = 1'b1;
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_cnt_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_cnt_reg     <= step_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign key_stall    = !ready;
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/keypad_integer_calculator_unit.sv
// top level of the keypad integer calculator
`timescale 1ns / 1ps
`default_nettype none

// Five-function integer calculator driven one key per transfer: digits build
// a decimal entry of up to ten digits, operators and evaluate combine it with a
// signed 32-bit running total (add, subtract, multiply, divide, modulo), and
// clear or reset is the only way out of the divide-by-zero error. Every key
// yields one result transfer carrying the displayed value, the error flag and
// the pending operator. A key is loaded and then applied, and its result is
// registered for transfer; a divide or modulo evaluation runs a bit-serial
// restoring divider between load and apply. A new key is taken once the
// previous result has left or leaves in the same cycle.
module keypad_integer_calculator_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              key_valid,
    output logic                                   key_stall,
    input  wire logic [kic_pkg::CMD_W-1:0]         command,
    input  wire logic [kic_pkg::DIGIT_W-1:0]       digit,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output logic signed [kic_pkg::VALUE_W-1:0]     shown_value,
    output logic                                   shown_error,
    output logic [kic_pkg::OPER_W-1:0]             waiting_operator
);

    kic_pkg::kic_ctrl_t ctrl;
    kic_pkg::kic_stat_t stat;

    kic_controller u_controller (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .ctrl         (ctrl),
        .stat         (stat)
    );

    kic_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .stat             (stat),
        .command          (command),
        .digit            (digit),
        .shown_value      (shown_value),
        .shown_error      (shown_error),
        .waiting_operator (waiting_operator)
    );

endmodule

`default_nettype wire
